### hw/rtl/csul_pkg.sv
// ----------------------------------------------------------------------------
// csul_pkg
// Shared sizes, opcodes and status codes of the character stack with undo log.
// ----------------------------------------------------------------------------
package csul_pkg;

    localparam int TEXT_DEPTH = 1024;
    localparam int LOG_DEPTH  = 1024;

    localparam int TEXT_AW     = $clog2(TEXT_DEPTH);
    localparam int LOG_CW      = $clog2(LOG_DEPTH + 1);
    localparam int LOG_AW      = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
    localparam int CHAR_W      = 8;
    localparam int LOG_ENTRY_W = CHAR_W + 1;

    localparam logic [TEXT_AW-1:0] TEXT_MAX = TEXT_AW'(TEXT_DEPTH - 1);
    localparam logic [LOG_CW-1:0]  LOG_MAX  = LOG_CW'(LOG_DEPTH);

    typedef enum logic [1:0] {
        OP_PUSH_CHAR = 2'd0,
        OP_POP_CHAR  = 2'd1,
        OP_UNDO      = 2'd2,
        OP_NONE      = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_DONE       = 2'd0,
        ST_TEXT_FULL  = 2'd1,
        ST_TEXT_EMPTY = 2'd2,
        ST_NO_UNDO    = 2'd3
    } status_t;

    typedef enum logic {
        KIND_APPEND = 1'b0,
        KIND_DELETE = 1'b1
    } edit_kind_t;

endpackage

### hw/rtl/char_stack_with_undo_log.sv
// ----------------------------------------------------------------------------
// char_stack_with_undo_log
// Byte text stack with an undo log stack, both held in synchronous memories.
// The item's operands and memory reads are registered at accept; its result is
// registered as it leaves EXEC. A new item is taken only once the last one finishes.
// in_ready drops while an item is at work; a result left waiting keeps it there.
// Reset clears both counts and the output valid; memory contents stay as is.
// ----------------------------------------------------------------------------
module char_stack_with_undo_log (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   opcode,
    input  logic [csul_pkg::CHAR_W-1:0]  char_in,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [1:0]                   status,
    output logic [csul_pkg::CHAR_W-1:0]  affected_char,
    output logic                         undo_kind,
    output logic                         log_recorded,
    output logic [csul_pkg::TEXT_AW-1:0] text_length,
    output logic [csul_pkg::LOG_CW-1:0]  log_depth
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t                              state_reg, state_next;
    logic [csul_pkg::TEXT_AW-1:0]        text_count_reg, text_count_next;
    logic [csul_pkg::LOG_CW-1:0]         log_count_reg, log_count_next;
    logic [1:0]                          op_reg;
    logic [csul_pkg::CHAR_W-1:0]         char_reg;

    logic                                out_valid_reg, out_valid_next;
    logic [1:0]                          status_reg, status_next;
    logic [csul_pkg::CHAR_W-1:0]         affected_reg, affected_next;
    logic                                kind_reg, kind_next;
    logic                                recorded_reg, recorded_next;

    logic [csul_pkg::CHAR_W-1:0]         text_mem [csul_pkg::TEXT_DEPTH];
    logic [csul_pkg::LOG_ENTRY_W-1:0]    log_mem  [csul_pkg::LOG_DEPTH];
    logic [csul_pkg::CHAR_W-1:0]         text_rd_reg;
    logic [csul_pkg::LOG_ENTRY_W-1:0]    log_rd_reg;

    logic                                accept;
    logic                                finish;
    logic [csul_pkg::TEXT_AW-1:0]        text_rd_addr;
    logic [csul_pkg::LOG_CW-1:0]         log_top;
    logic                                text_we;
    logic [csul_pkg::CHAR_W-1:0]         text_wdata;
    logic                                log_we;
    logic [csul_pkg::LOG_ENTRY_W-1:0]    log_wdata;
    logic                                log_room;

    assign in_ready      = (state_reg == S_IDLE);
    assign accept        = in_valid && in_ready;
    assign finish        = (state_reg == S_EXEC) && (!out_valid_reg || out_ready);
    assign text_rd_addr  = text_count_reg - 1'b1;
    assign log_top       = log_count_reg - 1'b1;
    assign log_room      = (log_count_reg < csul_pkg::LOG_MAX);

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign affected_char = affected_reg;
    assign undo_kind     = kind_reg;
    assign log_recorded  = recorded_reg;
    assign text_length   = text_count_reg;
    assign log_depth     = log_count_reg;

    // memories: read at accept, written when the item finishes
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            text_rd_reg <= text_mem[text_rd_addr];
            log_rd_reg  <= log_mem[log_top[csul_pkg::LOG_AW-1:0]];
        end
        if (text_we)
        begin
            text_mem[text_count_reg] <= text_wdata;
        end
        if (log_we)
        begin
            log_mem[log_count_reg[csul_pkg::LOG_AW-1:0]] <= log_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= opcode;
            char_reg <= char_in;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        text_count_next = text_count_reg;
        log_count_next  = log_count_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        status_next     = status_reg;
        affected_next   = affected_reg;
        kind_next       = kind_reg;
        recorded_next   = recorded_reg;
        text_we         = 1'b0;
        text_wdata      = char_reg;
        log_we          = 1'b0;
        log_wdata       = {csul_pkg::KIND_APPEND, char_reg};

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (finish)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                    status_next    = csul_pkg::ST_DONE;
                    affected_next  = '0;
                    kind_next      = 1'b0;
                    recorded_next  = 1'b0;
                    case (op_reg)
                        csul_pkg::OP_PUSH_CHAR:
                        begin
                            if (text_count_reg >= csul_pkg::TEXT_MAX)
                            begin
                                status_next = csul_pkg::ST_TEXT_FULL;
                            end
                            else
                            begin
                                text_we         = 1'b1;
                                text_wdata      = char_reg;
                                text_count_next = text_count_reg + 1'b1;
                                affected_next   = char_reg;
                                log_wdata       = {csul_pkg::KIND_APPEND, char_reg};
                                log_we          = log_room;
                                recorded_next   = log_room;
                                if (log_room)
                                begin
                                    log_count_next = log_count_reg + 1'b1;
                                end
                            end
                        end
                        csul_pkg::OP_POP_CHAR:
                        begin
                            if (text_count_reg == '0)
                            begin
                                status_next = csul_pkg::ST_TEXT_EMPTY;
                            end
                            else
                            begin
                                text_count_next = text_count_reg - 1'b1;
                                affected_next   = text_rd_reg;
                                log_wdata       = {csul_pkg::KIND_DELETE, text_rd_reg};
                                log_we          = log_room;
                                recorded_next   = log_room;
                                if (log_room)
                                begin
                                    log_count_next = log_count_reg + 1'b1;
                                end
                            end
                        end
                        csul_pkg::OP_UNDO:
                        begin
                            if (log_count_reg == '0)
                            begin
                                status_next = csul_pkg::ST_NO_UNDO;
                            end
                            else
                            begin
                                log_count_next = log_top;
                                kind_next      = log_rd_reg[csul_pkg::CHAR_W];
                                affected_next  = log_rd_reg[csul_pkg::CHAR_W-1:0];
                                if (log_rd_reg[csul_pkg::CHAR_W] == csul_pkg::KIND_APPEND)
                                begin
                                    if (text_count_reg != '0)
                                    begin
                                        text_count_next = text_count_reg - 1'b1;
                                    end
                                end
                                else if (text_count_reg < csul_pkg::TEXT_MAX)
                                begin
                                    text_we         = 1'b1;
                                    text_wdata      = log_rd_reg[csul_pkg::CHAR_W-1:0];
                                    text_count_next = text_count_reg + 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                            status_next = csul_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            text_count_reg <= '0;
            log_count_reg  <= '0;
            out_valid_reg  <= 1'b0;
            status_reg     <= csul_pkg::ST_DONE;
            affected_reg   <= '0;
            kind_reg       <= 1'b0;
            recorded_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            text_count_reg <= text_count_next;
            log_count_reg  <= log_count_next;
            out_valid_reg  <= out_valid_next;
            status_reg     <= status_next;
            affected_reg   <= affected_next;
            kind_reg       <= kind_next;
            recorded_reg   <= recorded_next;
        end
    end

    // checks
    a_log_bound: assert property (@(posedge clk) disable iff (!rst_n)
        log_count_reg <= csul_pkg::LOG_MAX)
        else $error("undo log count beyond depth");

    a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("item accepted while previous one at work");

    a_count_only_on_finish: assert property (@(posedge clk) disable iff (!rst_n)
        !finish |=> $stable(text_count_reg) && $stable(log_count_reg))
        else $error("count changed outside item completion");

    a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_EXEC))
        else $error("result shown without an item finishing");

    a_no_double_write: assert property (@(posedge clk) disable iff (!rst_n)
        (text_we || log_we) |-> finish)
        else $error("memory written outside item completion");

endmodule
